// ===== sv/ipu_pkg.sv =====
// Shared types, constants and helper functions of the indexed pixel unpacker.
package ipu_pkg;

   localparam int PALETTE_DEPTH = 256;
   localparam int PAL_ADDR_W = $clog2(PALETTE_DEPTH);
   localparam int MAX_DIMENSION = 4096;
   localparam int CNT_W = $clog2(MAX_DIMENSION + 1);
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int BPP_W = 4;
   localparam int DIM_W = 13;
   localparam int PSIZE_W = 9;
   localparam int ACC_W = 15;
   localparam int HELD_W = 4;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [PSIZE_W-1:0] PAL_LIMIT = PSIZE_W'(PALETTE_DEPTH);

   typedef enum logic [2:0] {
      REG_BPP    = 3'd0,
      REG_WIDTH  = 3'd1,
      REG_HEIGHT = 3'd2,
      REG_STRIDE = 3'd3,
      REG_PSIZE  = 3'd4
   } csr_reg_type;

   typedef enum logic [2:0] {
      MODE_IDLE   = 3'b001,
      MODE_WRITE  = 3'b010,
      MODE_UNPACK = 3'b100
   } mode_type;

   typedef enum logic [1:0] {
      JOB_WRITE = 2'd0,
      JOB_PIXEL = 2'd1,
      JOB_ERROR = 2'd2
   } job_kind_type;

   typedef struct packed {
      logic [BPP_W-1:0]   bpp;
      logic [CNT_W-1:0]   width;
      logic [CNT_W-1:0]   height;
      logic [CNT_W-1:0]   stride;
      logic [PSIZE_W-1:0] psize;
   } cfg_type;

   typedef struct packed {
      job_kind_type          kind;
      logic [PAL_ADDR_W-1:0] addr;
      logic [15:0]           color;
      logic                  last_of_run;
      logic                  row_end;
      logic                  frame_end;
   } job_type;

   typedef struct packed {
      logic [15:0] pixel_rgb565;
      logic        last_of_run;
      logic        row_end;
      logic        frame_end;
      logic        index_error;
   } rsp_type;

   function automatic logic [15:0] to_rgb565(input logic [31:0] argb);
      return {argb[23:19], argb[15:10], argb[7:3]};
   endfunction

   function automatic logic [CNT_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      logic [CNT_W-1:0] r;
      if (v == '0) begin
         r = CNT_W'(1);
      end else if (32'(v) > MAX_DIMENSION) begin
         r = CNT_W'(MAX_DIMENSION);
      end else begin
         r = CNT_W'(v);
      end
      return r;
   endfunction

endpackage

// ===== sv/ipu_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module ipu_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/ipu_front.sv =====
// Front end: accepts input beats, unpacks colour indices and issues jobs to the queue.
module ipu_front
   import ipu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        push,
   output logic        full,
   input  logic        op,
   input  logic [7:0]  palette_index,
   input  logic [31:0] palette_argb,
   input  logic [7:0]  source_byte,
   input  logic        frame_start,
   input  logic        q_full,
   output logic        q_push,
   output job_type     q_job
);

   mode_type              mode_ff, mode_in, mode_s;
   logic [ACC_W-1:0]      acc_ff, acc_in, acc_s, acc_next;
   logic [HELD_W-1:0]     held_ff, held_in, held_s, held_next;
   logic [CNT_W-1:0]      col_ff, col_in, col_s, col_next;
   logic [CNT_W-1:0]      rbc_ff, rbc_in, rbc_s, rbc_plus;
   logic [CNT_W-1:0]      row_ff, row_in, row_s;
   logic                  aborted_ff, aborted_in, aborted_s;
   logic [PAL_ADDR_W-1:0] wr_addr_ff, wr_addr_in;
   logic [15:0]           wr_color_ff, wr_color_in;

   logic [7:0]            mask;
   logic [7:0]            idx;
   logic                  more, more_next, idx_err;
   logic                  job_want, done, fin, accept;

   assign mask      = 8'hFF >> (4'd8 - cfg.bpp);
   assign idx       = acc_ff[7:0] & mask;
   assign idx_err   = {1'b0, idx} >= cfg.psize;
   assign more      = (held_ff >= cfg.bpp) && (col_ff < cfg.width);
   assign col_next  = col_ff + CNT_W'(1);
   assign held_next = held_ff - cfg.bpp;
   assign acc_next  = acc_ff >> cfg.bpp;
   assign more_next = (held_next >= cfg.bpp) && (col_next < cfg.width);
   assign rbc_plus  = rbc_ff + CNT_W'(1);

   always_comb begin
      mode_s    = mode_ff;
      acc_s     = acc_ff;
      held_s    = held_ff;
      col_s     = col_ff;
      rbc_s     = rbc_ff;
      row_s     = row_ff;
      aborted_s = aborted_ff;
      job_want  = 1'b0;
      q_job     = '0;
      done      = 1'b0;
      fin       = 1'b0;

      case (mode_ff)
         MODE_IDLE: begin
            done = 1'b1;
         end
         MODE_WRITE: begin
            job_want    = 1'b1;
            q_job.kind  = JOB_WRITE;
            q_job.addr  = wr_addr_ff;
            q_job.color = wr_color_ff;
            if (!q_full) begin
               done   = 1'b1;
               mode_s = MODE_IDLE;
            end
         end
         MODE_UNPACK: begin
            if (!more) begin
               fin = 1'b1;
            end else if (idx_err) begin
               job_want          = 1'b1;
               q_job.kind        = JOB_ERROR;
               q_job.last_of_run = 1'b1;
               if (!q_full) begin
                  aborted_s = 1'b1;
                  done      = 1'b1;
                  mode_s    = MODE_IDLE;
               end
            end else begin
               job_want          = 1'b1;
               q_job.kind        = JOB_PIXEL;
               q_job.addr        = idx[PAL_ADDR_W-1:0];
               q_job.last_of_run = !more_next;
               q_job.row_end     = (col_next == cfg.width);
               q_job.frame_end   = (col_next == cfg.width) &&
                                   (row_ff == cfg.height - CNT_W'(1));
               if (!q_full) begin
                  col_s  = col_next;
                  acc_s  = acc_next;
                  held_s = held_next;
                  fin    = !more_next;
               end
            end
         end
         default: begin
            mode_s = MODE_IDLE;
         end
      endcase

      if (fin) begin
         if (col_s >= cfg.width) begin
            acc_s  = '0;
            held_s = '0;
         end
         if (rbc_plus >= cfg.stride) begin
            rbc_s  = '0;
            col_s  = '0;
            acc_s  = '0;
            held_s = '0;
            row_s  = row_ff + CNT_W'(1);
         end else begin
            rbc_s = rbc_plus;
         end
         done   = 1'b1;
         mode_s = MODE_IDLE;
      end

      q_push = job_want && !q_full;
      full   = !done;
      accept = push && done;

      mode_in     = mode_s;
      acc_in      = acc_s;
      held_in     = held_s;
      col_in      = col_s;
      rbc_in      = rbc_s;
      row_in      = row_s;
      aborted_in  = aborted_s;
      wr_addr_in  = wr_addr_ff;
      wr_color_in = wr_color_ff;

      if (accept) begin
         if (!op) begin
            if ({1'b0, palette_index} < PAL_LIMIT) begin
               wr_addr_in  = palette_index[PAL_ADDR_W-1:0];
               wr_color_in = to_rgb565(palette_argb);
               mode_in     = MODE_WRITE;
            end
         end else begin
            if (frame_start) begin
               acc_in     = '0;
               held_in    = '0;
               col_in     = '0;
               rbc_in     = '0;
               row_in     = '0;
               aborted_in = 1'b0;
            end
            if (!aborted_in && (row_in < cfg.height)) begin
               if (col_in < cfg.width) begin
                  acc_in  = acc_in | (ACC_W'(source_byte) << held_in);
                  held_in = held_in + HELD_W'(8);
               end
               mode_in = MODE_UNPACK;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_IDLE;
         acc_ff     <= '0;
         held_ff    <= '0;
         col_ff     <= '0;
         rbc_ff     <= '0;
         row_ff     <= '0;
         aborted_ff <= 1'b0;
      end else begin
         mode_ff    <= mode_in;
         acc_ff     <= acc_in;
         held_ff    <= held_in;
         col_ff     <= col_in;
         rbc_ff     <= rbc_in;
         row_ff     <= row_in;
         aborted_ff <= aborted_in;
      end
      wr_addr_ff  <= wr_addr_in;
      wr_color_ff <= wr_color_in;
   end

   a_idle_takes_beat: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_IDLE) |-> !full)
      else $error("front is idle but refuses an input beat");

   a_abort_stops_unpack: assert property (@(posedge clock) disable iff (reset)
      aborted_ff |-> (mode_ff != MODE_UNPACK))
      else $error("front unpacks while the frame is aborted");

endmodule

// ===== sv/ipu_queue.sv =====
// Short job queue between the front end and the palette back end.
module ipu_queue
   import ipu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output job_type head,
   output logic    empty
);

   job_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("job pushed into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("job popped from an empty queue");

endmodule

// ===== sv/ipu_back.sv =====
// Back end: executes palette writes and lookups and holds the result register.
module ipu_back
   import ipu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  job_type head,
   input  logic    q_empty,
   output logic    q_pop,
   input  logic    pop,
   output logic    empty,
   output rsp_type rsp
);

   logic        s1_valid_ff, s1_valid_in;
   job_type     s1_job_ff, s1_job_in;
   logic        out_valid_ff, out_valid_in;
   rsp_type     out_ff, out_in;
   logic [15:0] rd_data;
   logic        out_free, s1_free, head_write, rd_en, wr_en;

   assign out_free   = !out_valid_ff || pop;
   assign s1_free    = !s1_valid_ff || out_free;
   assign head_write = (head.kind == JOB_WRITE);
   assign q_pop      = !q_empty && (head_write || s1_free);
   assign wr_en      = q_pop && head_write;
   assign rd_en      = q_pop && (head.kind == JOB_PIXEL);

   ipu_ram #(
      .WIDTH (16),
      .DEPTH (PALETTE_DEPTH)
   ) u_palette (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (head.addr),
      .wr_data (head.color),
      .rd_en   (rd_en),
      .rd_addr (head.addr),
      .rd_data (rd_data)
   );

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_job_in    = s1_job_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;

      if (s1_valid_ff && out_free) begin
         out_valid_in        = 1'b1;
         out_in.index_error  = (s1_job_ff.kind == JOB_ERROR);
         out_in.pixel_rgb565 = (s1_job_ff.kind == JOB_ERROR) ? 16'h0000 : rd_data;
         out_in.last_of_run  = s1_job_ff.last_of_run;
         out_in.row_end      = s1_job_ff.row_end;
         out_in.frame_end    = s1_job_ff.frame_end;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end

      if (q_pop && !head_write) begin
         s1_valid_in = 1'b1;
         s1_job_in   = head;
      end else if (out_free) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
      s1_job_ff <= s1_job_in;
      out_ff    <= out_in;
   end

   assign empty = !out_valid_ff;
   assign rsp   = out_ff;

   a_lookup_held_in_stall: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && out_valid_ff && !pop) |=> (s1_valid_ff && $stable(rd_data)))
      else $error("palette lookup lost while the result register is stalled");

endmodule

// ===== sv/indexed_pixel_unpack_palette_rgb565_top.sv =====
// Top level of the indexed pixel unpacker with RGB565 palette and register port.
//
// The input queue takes one beat per accepted push: op 0 loads a palette entry
// (ARGB8888 cut to RGB565), op 1 delivers one packed source byte in raster order.
// The result queue gives one pixel beat per pop, with row and frame end marks and
// last_of_run on the final beat caused by a source byte; a bad index gives a
// single error beat and the frame is dropped until the next frame_start. Registers
// are written through the APB-style port only while the block is idle, as a rule
// for the user; the block itself does not enforce it.
// A source byte passes the unpacker state registers, a job queue slot, the palette
// RAM read register and the result register before it reaches the ports. It holds
// the unpacker, even if it yields no pixel, until all its pixels are issued; a full
// job queue stalls it. The back end produces one result per cycle while the receiver
// pops, bounded by the single read port of the palette RAM.
//
// Reset clears all counters and the result path and restores the register
// defaults; palette contents stay undefined until loaded. When the receiver
// stops popping, the four-entry job queue fills and full rises on the input.
module indexed_pixel_unpack_palette_rgb565_top
   import ipu_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  logic                  req_op,
   input  logic [7:0]            req_palette_index,
   input  logic [31:0]           req_palette_argb,
   input  logic [7:0]            req_source_byte,
   input  logic                  req_frame_start,
   input  logic                  pop,
   output logic                  empty,
   output logic [15:0]           rsp_pixel_rgb565,
   output logic                  rsp_last_of_run,
   output logic                  rsp_row_end,
   output logic                  rsp_frame_end,
   output logic                  rsp_index_error,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic [BPP_W-1:0]   bpp_ff, bpp_in;
   logic [DIM_W-1:0]   width_ff, width_in;
   logic [DIM_W-1:0]   height_ff, height_in;
   logic [DIM_W-1:0]   stride_ff, stride_in;
   logic [PSIZE_W-1:0] psize_ff, psize_in;
   logic               csr_write;
   cfg_type            cfg;
   job_type            q_job, q_head;
   logic               q_push, q_full, q_pop, q_empty;
   rsp_type            rsp;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      bpp_in    = bpp_ff;
      width_in  = width_ff;
      height_in = height_ff;
      stride_in = stride_ff;
      psize_in  = psize_ff;
      if (csr_write) begin
         case (paddr[4:2])
            REG_BPP:    bpp_in    = pwdata[BPP_W-1:0];
            REG_WIDTH:  width_in  = pwdata[DIM_W-1:0];
            REG_HEIGHT: height_in = pwdata[DIM_W-1:0];
            REG_STRIDE: stride_in = pwdata[DIM_W-1:0];
            REG_PSIZE:  psize_in  = pwdata[PSIZE_W-1:0];
            default:    ;
         endcase
      end
   end

   always_comb begin
      case (paddr[4:2])
         REG_BPP:    prdata = CSR_DATA_W'(bpp_ff);
         REG_WIDTH:  prdata = CSR_DATA_W'(width_ff);
         REG_HEIGHT: prdata = CSR_DATA_W'(height_ff);
         REG_STRIDE: prdata = CSR_DATA_W'(stride_ff);
         REG_PSIZE:  prdata = CSR_DATA_W'(psize_ff);
         default:    prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff    <= BPP_W'(8);
         width_ff  <= DIM_W'(1);
         height_ff <= DIM_W'(1);
         stride_ff <= DIM_W'(1);
         psize_ff  <= PSIZE_W'(256);
      end else begin
         bpp_ff    <= bpp_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         stride_ff <= stride_in;
         psize_ff  <= psize_in;
      end
   end

   always_comb begin
      if (bpp_ff == '0) begin
         cfg.bpp = BPP_W'(1);
      end else if (bpp_ff > BPP_W'(8)) begin
         cfg.bpp = BPP_W'(8);
      end else begin
         cfg.bpp = bpp_ff;
      end
      cfg.width  = clamp_dim(width_ff);
      cfg.height = clamp_dim(height_ff);
      cfg.stride = clamp_dim(stride_ff);
      cfg.psize  = (psize_ff > PAL_LIMIT) ? PAL_LIMIT : psize_ff;
   end

   ipu_front u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .push          (push),
      .full          (full),
      .op            (req_op),
      .palette_index (req_palette_index),
      .palette_argb  (req_palette_argb),
      .source_byte   (req_source_byte),
      .frame_start   (req_frame_start),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_job         (q_job)
   );

   ipu_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (q_job),
      .full     (q_full),
      .pop      (q_pop),
      .head     (q_head),
      .empty    (q_empty)
   );

   ipu_back u_back (
      .clock   (clock),
      .reset   (reset),
      .head    (q_head),
      .q_empty (q_empty),
      .q_pop   (q_pop),
      .pop     (pop),
      .empty   (empty),
      .rsp     (rsp)
   );

   assign rsp_pixel_rgb565 = rsp.pixel_rgb565;
   assign rsp_last_of_run  = rsp.last_of_run;
   assign rsp_row_end      = rsp.row_end;
   assign rsp_frame_end    = rsp.frame_end;
   assign rsp_index_error  = rsp.index_error;

endmodule
